// ----- hdl/bmac_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmac_pkg
// Shared types, opcodes and constants of the byte memory access command block.
// ---------------------------------------------------------------------------
package bmac_pkg;

	localparam int MEM_DEPTH_DEF = 256;
	localparam int CMD_LEN       = 3;
	localparam int PTR_SKIP      = 4;

	// Opcodes: store/add/subtract, then compares ==, !=, >, >=, <=, <
	localparam logic [7:0] OP_SET_IMM = 8'd0;
	localparam logic [7:0] OP_ADD_IMM = 8'd1;
	localparam logic [7:0] OP_SUB_IMM = 8'd2;
	localparam logic [7:0] OP_SET_MEM = 8'd3;
	localparam logic [7:0] OP_ADD_MEM = 8'd4;
	localparam logic [7:0] OP_SUB_MEM = 8'd5;
	localparam logic [7:0] OP_EQ_IMM  = 8'd6;
	localparam logic [7:0] OP_NE_IMM  = 8'd7;
	localparam logic [7:0] OP_GT_IMM  = 8'd8;
	localparam logic [7:0] OP_GE_IMM  = 8'd9;
	localparam logic [7:0] OP_LE_IMM  = 8'd10;
	localparam logic [7:0] OP_LT_IMM  = 8'd11;
	localparam logic [7:0] OP_EQ_MEM  = 8'd12;
	localparam logic [7:0] OP_NE_MEM  = 8'd13;
	localparam logic [7:0] OP_GT_MEM  = 8'd14;
	localparam logic [7:0] OP_GE_MEM  = 8'd15;
	localparam logic [7:0] OP_LE_MEM  = 8'd16;
	localparam logic [7:0] OP_LT_MEM  = 8'd17;

	localparam logic [1:0] OUT_DONE = 2'd0;
	localparam logic [1:0] OUT_TAKE = 2'd1;
	localparam logic [1:0] OUT_SKIP = 2'd2;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] target_index;
		logic [7:0] operand;
	} cmd_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [2:0] cursor_advance;
		logic [7:0] target_value;
	} res_t;

	typedef struct packed {
		logic wr_en;
		res_t res;
	} exec_out_t;

endpackage
`default_nettype wire

// ----- hdl/bmac_stream_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmac_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface bmac_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/bmac_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmac_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module bmac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

// ----- hdl/bmac_exec.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bmac_exec
// Modify/compare unit: new target byte, outcome and cursor step of a command.
// ---------------------------------------------------------------------------
module bmac_exec (
	input  wire bmac_pkg::cmd_t    cmd,
	input  wire logic [7:0]        cur,
	input  wire logic [7:0]        src,
	output      bmac_pkg::exec_out_t result
);
	import bmac_pkg::*;

	logic [7:0] rhs;
	logic [7:0] new_val;
	logic       cond;

	// Immediate for the first group of each kind, indexed byte for the second
	assign rhs = (cmd.opcode inside {[OP_SET_MEM:OP_SUB_MEM], [OP_EQ_MEM:OP_LT_MEM]})
		? src : cmd.operand;

	always_comb begin
		case (cmd.opcode)
			OP_SET_IMM, OP_SET_MEM: new_val = rhs;
			OP_ADD_IMM, OP_ADD_MEM: new_val = cur + rhs;
			OP_SUB_IMM, OP_SUB_MEM: new_val = cur - rhs;
			default:                new_val = cur;
		endcase
	end

	always_comb begin
		case (cmd.opcode)
			OP_EQ_IMM, OP_EQ_MEM: cond = (cur == rhs);
			OP_NE_IMM, OP_NE_MEM: cond = (cur != rhs);
			OP_GT_IMM, OP_GT_MEM: cond = (cur > rhs);
			OP_GE_IMM, OP_GE_MEM: cond = (cur >= rhs);
			OP_LE_IMM, OP_LE_MEM: cond = (cur <= rhs);
			default:              cond = (cur < rhs);
		endcase
	end

	always_comb begin
		result.wr_en                 = 1'b0;
		result.res.outcome           = OUT_DONE;
		result.res.cursor_advance    = 3'(CMD_LEN);
		result.res.target_value      = new_val;
		if (cmd.opcode inside {[OP_SET_IMM:OP_SUB_MEM]}) begin
			result.wr_en = 1'b1;
		end else if (cmd.opcode inside {[OP_EQ_IMM:OP_LT_MEM]}) begin
			if (cond) begin
				result.res.outcome = OUT_TAKE;
			end else begin
				result.res.outcome        = OUT_SKIP;
				result.res.cursor_advance = 3'(CMD_LEN + PTR_SKIP);
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/byte_memory_access_command_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// byte_memory_access_command_top
// Runs three-byte sequencer memory-access commands against a byte work memory.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                   | transaction
//  --------+-----+-------------------------------------------+------------------------
//  cmd     | in  | opcode, target_index, operand             | valid & ready at clk
//  res     | out | outcome, cursor_advance, target_value     | valid & ready at clk
//
//  A command is accepted in ST_IDLE, which presents both read addresses
//  (target and operand byte) to the two read ports of the work RAM; ST_EXEC then
//  computes and writes the target byte back through the single write port.
//  After reset the block sweeps every work RAM address writing zeros, with cmd.ready low.
//  The result sits in an output register; a new command is taken while it waits,
//  and holds in the execute cycle only until the output register frees up.
//
module byte_memory_access_command_top #(
	parameter int MEM_DEPTH = bmac_pkg::MEM_DEPTH_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	bmac_stream_if.sink   cmd,
	bmac_stream_if.source res
);
	import bmac_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_cnt_q;
	cmd_t            cmd_s1;
	res_t            res_data_q;
	logic            res_valid_q;

	logic            cmd_acc;
	logic            exec_adv;
	logic [AW-1:0]   rd_tgt;
	logic [AW-1:0]   rd_src;
	logic [7:0]      cur_byte;
	logic [7:0]      src_byte;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [7:0]      mem_wdata;
	exec_out_t       exec_out;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid & cmd.ready;

	// Retire the command when the output register is empty or draining this cycle
	assign exec_adv  = (state_q == ST_EXEC) & (~res_valid_q | res.ready);

	// Read straight from the incoming command on accept, then keep re-reading the
	// held addresses so the read data stays valid across an output stall.
	assign rd_tgt = (state_q == ST_IDLE) ? cmd.data.target_index[AW-1:0]
		: cmd_s1.target_index[AW-1:0];
	assign rd_src = (state_q == ST_IDLE) ? cmd.data.operand[AW-1:0]
		: cmd_s1.operand[AW-1:0];

	// Write port: zero sweep after reset, otherwise the modified target byte
	assign mem_we    = (state_q == ST_CLEAR) | (exec_adv & exec_out.wr_en);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : cmd_s1.target_index[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : exec_out.res.target_value;

	bmac_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_work_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (rd_tgt),
		.rdata_a (cur_byte),
		.raddr_b (rd_src),
		.rdata_b (src_byte)
	);

	// Source and target are read in the same cycle, before any write-back, so an
	// aliased operand index sees the old byte as required.
	bmac_exec u_exec (
		.cmd    (cmd_s1),
		.cur    (cur_byte),
		.src    (src_byte),
		.result (exec_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Command hold register: payload only
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1 <= cmd.data;
		end
	end

	// Output register: fill on retire, drop on a completed res transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_adv) begin
			res_data_q <= exec_out.res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule
`default_nettype wire
